// File: rtl/lds_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lds_pkg
// Shared types and constants of the loop load statistics block.
// ----------------------------------------------------------------------------
package lds_pkg;

	localparam int unsigned LOAD_W   = 18;
	localparam int unsigned CNT_W    = 16;
	localparam int unsigned TIME_W   = 16;
	localparam int unsigned DIV_DW   = 31;
	localparam int unsigned DIV_VW   = 32;
	localparam int unsigned DIV_SW   = 5;
	localparam int unsigned BIN_AW   = 4;
	localparam int unsigned PADDR_W  = 3;

	localparam logic [LOAD_W-1:0] FULL_LOAD  = 18'd25600;
	localparam logic [LOAD_W-1:0] LOAD_MAX   = 18'd262143;
	localparam logic [TIME_W-1:0] LOOP_RESET = 16'd100;
	localparam logic [DIV_SW-1:0] LOAD_STEPS = 5'd31;
	localparam logic [DIV_SW-1:0] MEAN_STEPS = 5'd18;
	localparam logic [DIV_VW-1:0] TOTAL_WRAP = 32'hFFFF_FFFF;

	localparam logic ACT_RECORD = 1'b0;
	localparam logic ACT_QUERY  = 1'b1;

	localparam logic REG_LOOP_TIME = 1'b0;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOAD_DIV,
		S_MEAN,
		S_MEAN_DIV,
		S_STATS,
		S_BIN_INC,
		S_BIN_RD,
		S_DONE
	} state_t;

	typedef struct packed {
		logic              start;
		logic [DIV_SW-1:0] steps;
		logic [DIV_DW-1:0] dividend;
		logic [DIV_VW-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [DIV_DW-1:0] quotient;
	} div_rsp_t;

	typedef struct packed {
		logic              rd_en;
		logic              wr_en;
		logic [BIN_AW-1:0] addr;
		logic [CNT_W-1:0]  wr_data;
	} bin_req_t;

endpackage

`default_nettype wire

// File: rtl/loop_load_statistics.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// loop_load_statistics
// Loop load meter: wait time, Q10.8 load, mean, min, max and histogram.
// ----------------------------------------------------------------------------
// One word at a time. A record word first runs the bit-serial divider for
// the load (31 quotient bits), then sets up the running mean step and runs
// that step through the same divider (18 quotient bits; skipped when the
// record total wraps), then updates the statistics and accesses the histogram
// memory. A query word only reads the histogram memory. The result sits in an
// output register and the next word is taken in the cycle after it is loaded;
// a stalled result holds the block only while the output register is still
// full. loop_time_ms lies at byte address 0 and reads back through prdata.
// ----------------------------------------------------------------------------
module loop_load_statistics #(
	parameter int unsigned NUM_BINS = 10
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [lds_pkg::PADDR_W-1:0]   paddr,
	input  wire logic [31:0]                   pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic                          action,
	input  wire logic [lds_pkg::TIME_W-1:0]    elapsed_ms,
	input  wire logic [7:0]                    bin_index,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [lds_pkg::TIME_W-1:0]         wait_ms,
	output logic                               late,
	output logic [lds_pkg::LOAD_W-1:0]         load_now,
	output logic [lds_pkg::LOAD_W-1:0]         load_mean,
	output logic [lds_pkg::LOAD_W-1:0]         load_least,
	output logic [lds_pkg::LOAD_W-1:0]         load_most,
	output logic [lds_pkg::CNT_W-1:0]          bin_count,
	output logic [lds_pkg::CNT_W-1:0]          overload_count
);

	localparam int unsigned LW = lds_pkg::LOAD_W;
	localparam int unsigned CW = lds_pkg::CNT_W;
	localparam int unsigned TW = lds_pkg::TIME_W;

	lds_pkg::state_t   state_q, state_d;
	lds_pkg::div_req_t div_req;
	lds_pkg::div_rsp_t div_rsp;
	lds_pkg::bin_req_t bin_req;
	logic [CW-1:0]     bin_rd;

	logic [TW-1:0]     loop_time_q;
	logic [LW-1:0]     mean_q, least_q, most_q;
	logic [31:0]       total_q;
	logic [CW-1:0]     ovl_q;
	logic              out_valid_q;

	logic [TW-1:0]     wait_q;
	logic              late_q;
	logic [LW-1:0]     load_q;
	logic [7:0]        bin_index_q;
	logic              neg_q;

	logic [TW-1:0]     wait_ms_q;
	logic              late_out_q;
	logic [LW-1:0]     load_now_q, load_mean_q, load_least_q, load_most_q;
	logic [CW-1:0]     bin_count_q, overload_count_q;

	logic              cfg_wr;
	logic              accept;
	logic              out_free;
	logic              out_load;
	logic [31:0]       total_inc;
	logic              total_full;
	logic [LW:0]       mean_diff;
	logic [LW:0]       mean_neg;
	logic [LW-1:0]     mean_mag;
	logic [LW-1:0]     mean_step;
	logic [LW-1:0]     load_sat;
	logic [17:0]       idx_prod;
	logic [6:0]        idx;
	logic              bin_hit;
	logic              query_ok;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == lds_pkg::REG_LOOP_TIME);

	always_comb begin
		prdata = '0;
		if (paddr[2] == lds_pkg::REG_LOOP_TIME) begin
			prdata = {16'd0, loop_time_q};
		end
	end

	assign accept     = in_valid && !in_stall;
	assign out_free   = !out_valid_q || !out_stall;
	assign total_inc  = total_q + 32'd1;
	assign total_full = (total_inc == lds_pkg::TOTAL_WRAP);
	assign mean_diff  = {1'b0, load_q} - {1'b0, mean_q};
	assign mean_neg   = -mean_diff;
	assign mean_mag   = mean_diff[LW] ? mean_neg[LW-1:0] : mean_diff[LW-1:0];
	assign mean_step  = div_rsp.quotient[LW-1:0];
	assign load_sat   = (|div_rsp.quotient[lds_pkg::DIV_DW-1:LW]) ? lds_pkg::LOAD_MAX
	                  : div_rsp.quotient[LW-1:0];
	// whole tens of percent: (load >> 8) / 10 by reciprocal 205 / 2048
	assign idx_prod   = {8'd0, load_q[LW-1:8]} * 18'd205;
	assign idx        = idx_prod[17:11];
	assign bin_hit    = (idx < 7'(NUM_BINS));
	assign query_ok   = (bin_index_q < 8'(NUM_BINS));

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			lds_pkg::S_IDLE: begin
				if (in_valid) begin
					state_d = (action == lds_pkg::ACT_QUERY) ? lds_pkg::S_BIN_RD
					        : lds_pkg::S_LOAD_DIV;
				end
			end
			lds_pkg::S_LOAD_DIV: begin
				if (div_rsp.done) state_d = lds_pkg::S_MEAN;
			end
			lds_pkg::S_MEAN: begin
				state_d = total_full ? lds_pkg::S_STATS : lds_pkg::S_MEAN_DIV;
			end
			lds_pkg::S_MEAN_DIV: begin
				if (div_rsp.done) state_d = lds_pkg::S_STATS;
			end
			lds_pkg::S_STATS: begin
				state_d = bin_hit ? lds_pkg::S_BIN_INC : lds_pkg::S_BIN_RD;
			end
			lds_pkg::S_BIN_INC: begin
				state_d = lds_pkg::S_BIN_RD;
			end
			lds_pkg::S_BIN_RD: begin
				state_d = lds_pkg::S_DONE;
			end
			lds_pkg::S_DONE: begin
				if (out_free) state_d = lds_pkg::S_IDLE;
			end
			default: begin
				state_d = lds_pkg::S_IDLE;
			end
		endcase
	end

	// state outputs
	always_comb begin
		in_stall         = 1'b1;
		out_load         = 1'b0;
		div_req.start    = 1'b0;
		div_req.steps    = lds_pkg::LOAD_STEPS;
		div_req.dividend = '0;
		div_req.divisor  = '0;
		bin_req.rd_en    = 1'b0;
		bin_req.wr_en    = 1'b0;
		bin_req.addr     = '0;
		bin_req.wr_data  = bin_rd + 16'd1;
		case (state_q)
			lds_pkg::S_IDLE: begin
				in_stall         = 1'b0;
				div_req.start    = in_valid && (action == lds_pkg::ACT_RECORD);
				div_req.dividend = lds_pkg::DIV_DW'({15'd0, elapsed_ms} * 31'd25600);
				div_req.divisor  = (loop_time_q == '0) ? 32'd1 : {16'd0, loop_time_q};
			end
			lds_pkg::S_MEAN: begin
				div_req.start    = !total_full;
				div_req.steps    = lds_pkg::MEAN_STEPS;
				div_req.dividend = {mean_mag, 13'd0};
				div_req.divisor  = total_inc;
			end
			lds_pkg::S_STATS: begin
				bin_req.rd_en = bin_hit;
				bin_req.addr  = idx[lds_pkg::BIN_AW-1:0];
			end
			lds_pkg::S_BIN_INC: begin
				bin_req.wr_en = 1'b1;
				bin_req.addr  = idx[lds_pkg::BIN_AW-1:0];
			end
			lds_pkg::S_BIN_RD: begin
				bin_req.rd_en = query_ok;
				bin_req.addr  = bin_index_q[lds_pkg::BIN_AW-1:0];
			end
			lds_pkg::S_DONE: begin
				out_load = out_free;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lds_pkg::S_IDLE;
			loop_time_q <= lds_pkg::LOOP_RESET;
			mean_q      <= '0;
			least_q     <= lds_pkg::FULL_LOAD;
			most_q      <= '0;
			total_q     <= '0;
			ovl_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr) loop_time_q <= pwdata[TW-1:0];
			if (state_q == lds_pkg::S_MEAN) begin
				total_q <= total_full ? 32'd0 : total_inc;
			end
			if ((state_q == lds_pkg::S_MEAN_DIV) && div_rsp.done) begin
				mean_q <= neg_q ? (mean_q - mean_step) : (mean_q + mean_step);
			end
			if (state_q == lds_pkg::S_STATS) begin
				if (load_q > most_q) most_q <= load_q;
				if (load_q < least_q) least_q <= load_q;
				if (!bin_hit) ovl_q <= ovl_q + 16'd1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			bin_index_q <= bin_index;
			load_q      <= '0;
			if ((action == lds_pkg::ACT_RECORD) && (elapsed_ms > loop_time_q)) begin
				late_q <= 1'b1;
				wait_q <= '0;
			end else if (action == lds_pkg::ACT_RECORD) begin
				late_q <= 1'b0;
				wait_q <= loop_time_q - elapsed_ms;
			end else begin
				late_q <= 1'b0;
				wait_q <= '0;
			end
		end
		if ((state_q == lds_pkg::S_LOAD_DIV) && div_rsp.done) begin
			load_q <= load_sat;
		end
		if (state_q == lds_pkg::S_MEAN) begin
			neg_q <= mean_diff[LW];
		end
		if (out_load) begin
			wait_ms_q        <= wait_q;
			late_out_q       <= late_q;
			load_now_q       <= load_q;
			load_mean_q      <= mean_q;
			load_least_q     <= least_q;
			load_most_q      <= most_q;
			bin_count_q      <= query_ok ? bin_rd : '0;
			overload_count_q <= ovl_q;
		end
	end

	lds_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	lds_bins #(
		.NUM_BINS (NUM_BINS)
	) u_bins (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (bin_req),
		.rd_data (bin_rd)
	);

	assign out_valid      = out_valid_q;
	assign wait_ms        = wait_ms_q;
	assign late           = late_out_q;
	assign load_now       = load_now_q;
	assign load_mean      = load_mean_q;
	assign load_least     = load_least_q;
	assign load_most      = load_most_q;
	assign bin_count      = bin_count_q;
	assign overload_count = overload_count_q;

endmodule

`default_nettype wire

// File: rtl/lds_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lds_div
// Bit-serial restoring divider, one quotient bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module lds_div (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire lds_pkg::div_req_t req,
	output lds_pkg::div_rsp_t      rsp
);

	logic [lds_pkg::DIV_VW-1:0] rem_q;
	logic [lds_pkg::DIV_DW-1:0] quo_q;
	logic [lds_pkg::DIV_VW-1:0] divisor_q;
	logic [lds_pkg::DIV_SW-1:0] cnt_q;
	logic                       busy_q;
	logic                       done_q;

	logic [lds_pkg::DIV_VW:0]   trial;
	logic [lds_pkg::DIV_VW:0]   diff;
	logic                       fits;

	assign trial = {rem_q, quo_q[lds_pkg::DIV_DW-1]};
	assign diff  = trial - {1'b0, divisor_q};
	assign fits  = !diff[lds_pkg::DIV_VW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == lds_pkg::DIV_SW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q     <= '0;
			quo_q     <= req.dividend;
			divisor_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[lds_pkg::DIV_VW-1:0] : trial[lds_pkg::DIV_VW-1:0];
			quo_q <= {quo_q[lds_pkg::DIV_DW-2:0], fits};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

`default_nettype wire

// File: rtl/lds_bins.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lds_bins
// Histogram counter memory with per-entry valid bits and registered read.
// ----------------------------------------------------------------------------
module lds_bins #(
	parameter int unsigned NUM_BINS = 10
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire lds_pkg::bin_req_t          req,
	output logic [lds_pkg::CNT_W-1:0]       rd_data
);

	localparam int unsigned IW = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;

	logic [lds_pkg::CNT_W-1:0] mem [NUM_BINS];
	logic [NUM_BINS-1:0]       valid_q;
	logic [lds_pkg::CNT_W-1:0] rd_q;
	logic [IW-1:0]             addr;

	assign addr = req.addr[IW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (req.wr_en) begin
			valid_q[addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_q <= valid_q[addr] ? mem[addr] : '0;
		end
	end

	assign rd_data = rd_q;

endmodule

`default_nettype wire

// File: rtl/lds_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lds_checker
// Port-level checks of the loop load statistics block.
// ----------------------------------------------------------------------------
module lds_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        out_valid,
	input wire logic                        out_stall,
	input wire logic [lds_pkg::TIME_W-1:0]  wait_ms,
	input wire logic                        late,
	input wire logic [lds_pkg::LOAD_W-1:0]  load_now,
	input wire logic [lds_pkg::LOAD_W-1:0]  load_mean,
	input wire logic [lds_pkg::LOAD_W-1:0]  load_least,
	input wire logic [lds_pkg::LOAD_W-1:0]  load_most
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("stalled word dropped");

	a_late_wait: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && late |-> wait_ms == '0)
		else $error("late word with nonzero wait");

	a_late_load: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && late |-> load_now >= lds_pkg::FULL_LOAD)
		else $error("late word below full load");

	a_stats: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (load_least <= lds_pkg::FULL_LOAD) && (load_mean <= load_most))
		else $error("statistics out of order");

endmodule

bind loop_load_statistics lds_checker u_lds_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.wait_ms    (wait_ms),
	.late       (late),
	.load_now   (load_now),
	.load_mean  (load_mean),
	.load_least (load_least),
	.load_most  (load_most)
);

`default_nettype wire
